>>> hw/rtl/mmrn_pkg.sv
// ----------------------------------------------------------------------------
// mmrn_pkg: shared types and constants of the min/max range normalizer
// Mode codes, register indexes, result record and fixed arithmetic widths.
// ----------------------------------------------------------------------------
package mmrn_pkg;

    // Request modes
    typedef enum logic {
        MODE_SCAN = 1'b0,
        MODE_MAP  = 1'b1
    } t_mode;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET_LOW  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET_HIGH = 2'd1;

    // Target range words are fixed signed Q16.16
    localparam int TARGET_BITS = 32;
    localparam logic signed [TARGET_BITS-1:0] TARGET_LOW_RST  = 32'sd0;
    localparam logic signed [TARGET_BITS-1:0] TARGET_HIGH_RST = 32'sd65536;
    localparam logic signed [TARGET_BITS-1:0] RESULT_MAX      = 32'sh7fff_ffff;
    localparam logic signed [TARGET_BITS-1:0] RESULT_MIN      = 32'sh8000_0000;

    // Quotient bits kept by the divider; anything larger always saturates
    localparam int QUOT_BITS = TARGET_BITS + 2;
    localparam int STEP_BITS = $clog2(QUOT_BITS);

    // Multiplier: target span magnitude taken in chunks, top chunk first
    localparam int MUL_CHUNK = 17;
    localparam int MUL_STEPS = 2;

    // Back end sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_CHECK,
        BK_DIV,
        BK_DONE
    } t_back_state;

    // One result
    typedef struct packed {
        logic [TARGET_BITS-1:0] mapped_value;
        logic                   degenerate;
        logic                   saturated;
    } t_result;

endpackage

>>> hw/rtl/mmrn_front.sv
// ----------------------------------------------------------------------------
// mmrn_front: request intake and range tracking
// Scan requests update the running min/max; map requests are turned into
// an offset, a range width and a degenerate flag and pushed to the queue.
// ----------------------------------------------------------------------------
module mmrn_front #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_mode,
    input  logic                   i_first_of_scan,
    input  logic [SAMPLE_BITS-1:0] i_sample_value,
    output logic                   o_push,
    input  logic                   i_push_ready,
    output logic [SAMPLE_BITS:0]   o_push_dv,
    output logic [SAMPLE_BITS-1:0] o_push_dr,
    output logic                   o_push_deg
);

    localparam logic signed [SAMPLE_BITS-1:0] MAX_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] MIN_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] r_min, n_min;
    logic signed [SAMPLE_BITS-1:0] r_max, n_max;
    logic signed [SAMPLE_BITS-1:0] w_sample;
    logic signed [SAMPLE_BITS-1:0] w_base_min, w_base_max;
    logic signed [SAMPLE_BITS:0]   w_dv, w_range;
    logic                          w_accept, w_is_map;

    assign w_sample = $signed(i_sample_value);
    assign w_accept = i_valid && i_push_ready;
    assign w_is_map = (mmrn_pkg::t_mode'(i_mode) == mmrn_pkg::MODE_MAP);
    assign o_ready  = i_push_ready;

    // Scan: restart on first flag, then two independent compares
    always_comb begin
        w_base_min = i_first_of_scan ? MAX_POS : r_min;
        w_base_max = i_first_of_scan ? MIN_NEG : r_max;
        n_min      = (w_sample < w_base_min) ? w_sample : w_base_min;
        n_max      = (w_sample > w_base_max) ? w_sample : w_base_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MAX_POS;
            r_max <= MIN_NEG;
        end else if (w_accept && !w_is_map) begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    // Map: offset from min and range width, one bit wider than a sample
    assign w_dv    = $signed({w_sample[SAMPLE_BITS-1], w_sample})
                   - $signed({r_min[SAMPLE_BITS-1], r_min});
    assign w_range = $signed({r_max[SAMPLE_BITS-1], r_max})
                   - $signed({r_min[SAMPLE_BITS-1], r_min});

    assign o_push     = w_accept && w_is_map;
    assign o_push_dv  = w_dv;
    assign o_push_dr  = w_range[SAMPLE_BITS-1:0];
    assign o_push_deg = !(r_max > r_min);

endmodule

>>> hw/rtl/mmrn_queue.sv
// ----------------------------------------------------------------------------
// mmrn_queue: two-entry queue between front and back
// Lets the front keep taking scan requests while the back divides.
// ----------------------------------------------------------------------------
module mmrn_queue #(
    parameter int DATA_BITS = 66
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [DATA_BITS-1:0] i_push_data,
    output logic                 o_push_ready,
    output logic                 o_pop_valid,
    input  logic                 i_pop,
    output logic [DATA_BITS-1:0] o_pop_data
);

    localparam int DEPTH      = 2;
    localparam int PTR_BITS   = $clog2(DEPTH);
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0]  r_mem [DEPTH];
    logic [PTR_BITS-1:0]   r_wptr, r_rptr;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  w_do_push, w_do_pop;

    assign o_push_ready = (r_count != COUNT_BITS'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rptr];
    assign w_do_push    = i_push && o_push_ready;
    assign w_do_pop     = i_pop && o_pop_valid;

    // Occupancy
    always_comb begin
        n_count = r_count;
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (w_do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

>>> hw/rtl/mmrn_back.sv
// ----------------------------------------------------------------------------
// mmrn_back: multiply, divide and saturate one map request
// Chunked multiply of the offset by the target span, restoring divide by
// the range width, then add to target_low with 32-bit saturation.
// ----------------------------------------------------------------------------
module mmrn_back #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_req_valid,
    output logic                                   o_req_ready,
    input  logic [SAMPLE_BITS:0]                   i_req_dv,
    input  logic [SAMPLE_BITS-1:0]                 i_req_dr,
    input  logic                                   i_req_deg,
    input  logic [mmrn_pkg::TARGET_BITS-1:0]       i_target_low,
    input  logic [mmrn_pkg::TARGET_BITS-1:0]       i_target_high,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output mmrn_pkg::t_result                      o_result
);

    localparam int TB = mmrn_pkg::TARGET_BITS;
    localparam int QB = mmrn_pkg::QUOT_BITS;
    localparam int CB = mmrn_pkg::MUL_CHUNK;
    localparam int MS = mmrn_pkg::MUL_STEPS;
    localparam int SB = mmrn_pkg::STEP_BITS;
    localparam int AB = SAMPLE_BITS + 1;
    localparam int BB = CB * MS;
    localparam int PW = AB + BB;

    mmrn_pkg::t_back_state r_state, n_state;

    logic [AB-1:0]          r_a;
    logic [BB-1:0]          r_b;
    logic [SAMPLE_BITS-1:0] r_dr;
    logic                   r_neg, r_deg, r_big;
    logic [PW-1:0]          r_acc;
    logic [SAMPLE_BITS-1:0] r_rem;
    logic [QB-1:0]          r_quo;
    logic [SB-1:0]          r_step;
    logic                   r_out_valid;
    mmrn_pkg::t_result      r_out, w_result;

    logic signed [TB:0]     w_dt;
    logic [TB-1:0]          w_dt_mag;
    logic [AB-1:0]          w_dv_mag;
    logic [AB+CB-1:0]       w_prod;
    logic [PW-1:0]          w_acc_next;
    logic [AB-1:0]          w_hi;
    logic                   w_big;
    logic [SAMPLE_BITS:0]   w_rem2, w_diff;
    logic                   w_ge;
    logic signed [QB+1:0]   w_tl_ext, w_q_ext, w_sum;
    logic                   w_fits;
    logic                   w_out_free, w_load_out, w_mul_last, w_div_last;

    // Operand magnitudes and sign of the product
    assign w_dt     = $signed({i_target_high[TB-1], i_target_high})
                    - $signed({i_target_low[TB-1], i_target_low});
    assign w_dt_mag = w_dt[TB] ? TB'(-w_dt) : TB'(w_dt);
    assign w_dv_mag = i_req_dv[AB-1] ? AB'(-$signed(i_req_dv)) : i_req_dv;

    // One chunk of the multiply per cycle, top chunk first
    assign w_prod     = r_a * r_b[BB-1 -: CB];
    assign w_acc_next = (r_acc << CB) + PW'(w_prod);

    // Quotient overflow: high product bits already reach the divisor
    assign w_hi  = r_acc[PW-1:QB];
    assign w_big = (w_hi >= {1'b0, r_dr});

    // Restoring divide step
    assign w_rem2 = {r_rem, r_quo[QB-1]};
    assign w_ge   = (w_rem2 >= {1'b0, r_dr});
    assign w_diff = w_rem2 - {1'b0, r_dr};

    // Signed sum and saturation
    assign w_tl_ext = $signed({{(QB+2-TB){i_target_low[TB-1]}}, i_target_low});
    assign w_q_ext  = $signed({2'b00, r_quo});
    assign w_sum    = r_neg ? (w_tl_ext - w_q_ext) : (w_tl_ext + w_q_ext);
    assign w_fits   = (w_sum[QB+1:TB-1] == '0) || (w_sum[QB+1:TB-1] == '1);

    always_comb begin
        w_result = '0;
        if (r_deg) begin
            w_result.mapped_value = i_target_low;
            w_result.degenerate   = 1'b1;
        end else if (r_big) begin
            w_result.mapped_value = r_neg ? mmrn_pkg::RESULT_MIN : mmrn_pkg::RESULT_MAX;
            w_result.saturated    = 1'b1;
        end else if (!w_fits) begin
            w_result.mapped_value = w_sum[QB+1] ? mmrn_pkg::RESULT_MIN
                                                : mmrn_pkg::RESULT_MAX;
            w_result.saturated    = 1'b1;
        end else begin
            w_result.mapped_value = w_sum[TB-1:0];
        end
    end

    assign w_mul_last = (r_step == SB'(MS - 1));
    assign w_div_last = (r_step == SB'(QB - 1));
    assign w_out_free = !r_out_valid || i_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mmrn_pkg::BK_IDLE: begin
                if (i_req_valid) begin
                    n_state = i_req_deg ? mmrn_pkg::BK_DONE : mmrn_pkg::BK_MUL;
                end
            end
            mmrn_pkg::BK_MUL: begin
                if (w_mul_last) begin
                    n_state = mmrn_pkg::BK_CHECK;
                end
            end
            mmrn_pkg::BK_CHECK: begin
                n_state = w_big ? mmrn_pkg::BK_DONE : mmrn_pkg::BK_DIV;
            end
            mmrn_pkg::BK_DIV: begin
                if (w_div_last) begin
                    n_state = mmrn_pkg::BK_DONE;
                end
            end
            mmrn_pkg::BK_DONE: begin
                if (w_out_free) begin
                    n_state = mmrn_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = mmrn_pkg::BK_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        o_req_ready = (r_state == mmrn_pkg::BK_IDLE);
        w_load_out  = (r_state == mmrn_pkg::BK_DONE) && w_out_free;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mmrn_pkg::BK_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == mmrn_pkg::BK_MUL || r_state == mmrn_pkg::BK_DIV) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            mmrn_pkg::BK_IDLE: begin
                r_a   <= w_dv_mag;
                r_b   <= BB'(w_dt_mag);
                r_dr  <= i_req_dr;
                r_neg <= i_req_dv[AB-1] ^ w_dt[TB];
                r_deg <= i_req_deg;
                r_big <= 1'b0;
                r_acc <= '0;
            end
            mmrn_pkg::BK_MUL: begin
                r_acc <= w_acc_next;
                r_b   <= r_b << CB;
            end
            mmrn_pkg::BK_CHECK: begin
                r_big <= w_big;
                r_rem <= w_hi[SAMPLE_BITS-1:0];
                r_quo <= r_acc[QB-1:0];
            end
            mmrn_pkg::BK_DIV: begin
                r_rem <= w_ge ? w_diff[SAMPLE_BITS-1:0] : w_rem2[SAMPLE_BITS-1:0];
                r_quo <= {r_quo[QB-2:0], w_ge};
            end
            default: begin
            end
        endcase
        if (w_load_out) begin
            r_out <= w_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

>>> hw/rtl/min_max_range_normalizer.sv
// ----------------------------------------------------------------------------
// min_max_range_normalizer: two-pass min/max normalization of Q16.16 samples
// Scan requests track the sample range; map requests rescale a sample
// from the scanned range to [target_low, target_high].
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries mode, first_of_scan and sample.
//   A scan request (mode 0) updates min/max and yields no result; the front
//   takes one per cycle while the queue has room. A map request (mode 1)
//   yields one result on the output channel (o_valid/i_ready).
//   A map request passes through the queue entry, the chunked multiply, an
//   overflow check, 34 restoring divide steps (one quotient bit per cycle)
//   and the output load; a degenerate range skips the arithmetic. The single
//   shared divider takes a new map request only once done with the last one.
//   The user must write target_low/target_high through i_cfg_we/i_cfg_index/
//   i_cfg_data only while the block is idle; the block does not enforce it.
//   Indexes beyond 1 are ignored.
//   Reset clears the queue and output register, sets min/max to empty and
//   loads the default target range [0, 1.0].
//   A stalled receiver holds the result in the output register; the back
//   end finishes its next request and waits, and the two-entry queue then
//   fills before o_ready drops.
// ----------------------------------------------------------------------------
module min_max_range_normalizer #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic                                      i_mode,
    input  logic                                      i_first_of_scan,
    input  logic [SAMPLE_BITS-1:0]                    i_sample_value,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic [mmrn_pkg::TARGET_BITS-1:0]          o_mapped_value,
    output logic                                      o_degenerate,
    output logic                                      o_saturated,
    input  logic                                      i_cfg_we,
    input  logic [mmrn_pkg::CFG_INDEX_BITS-1:0]       i_cfg_index,
    input  logic [mmrn_pkg::TARGET_BITS-1:0]          i_cfg_data
);

    localparam int QW = (SAMPLE_BITS + 1) + SAMPLE_BITS + 1;

    logic [mmrn_pkg::TARGET_BITS-1:0] r_target_low, r_target_high;

    logic                   w_push, w_push_ready, w_pop_valid, w_pop;
    logic [SAMPLE_BITS:0]   w_push_dv, w_pop_dv;
    logic [SAMPLE_BITS-1:0] w_push_dr, w_pop_dr;
    logic                   w_push_deg, w_pop_deg;
    logic [QW-1:0]          w_pop_data;
    mmrn_pkg::t_result      w_result;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_low  <= mmrn_pkg::TARGET_LOW_RST;
            r_target_high <= mmrn_pkg::TARGET_HIGH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mmrn_pkg::CFG_TARGET_LOW:  r_target_low  <= i_cfg_data;
                mmrn_pkg::CFG_TARGET_HIGH: r_target_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mmrn_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_first_of_scan (i_first_of_scan),
        .i_sample_value  (i_sample_value),
        .o_push          (w_push),
        .i_push_ready    (w_push_ready),
        .o_push_dv       (w_push_dv),
        .o_push_dr       (w_push_dr),
        .o_push_deg      (w_push_deg)
    );

    mmrn_queue #(
        .DATA_BITS (QW)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_data  ({w_push_dv, w_push_dr, w_push_deg}),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .i_pop        (w_pop),
        .o_pop_data   (w_pop_data)
    );

    assign {w_pop_dv, w_pop_dr, w_pop_deg} = w_pop_data;

    mmrn_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (w_pop_valid),
        .o_req_ready   (w_pop),
        .i_req_dv      (w_pop_dv),
        .i_req_dr      (w_pop_dr),
        .i_req_deg     (w_pop_deg),
        .i_target_low  (r_target_low),
        .i_target_high (r_target_high),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result      (w_result)
    );

    assign o_mapped_value = w_result.mapped_value;
    assign o_degenerate   = w_result.degenerate;
    assign o_saturated    = w_result.saturated;

endmodule

>>> hw/rtl/mmrn_checker.sv
// ----------------------------------------------------------------------------
// mmrn_checker: port-level checks for the min/max range normalizer
// Watches the result channel and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
module mmrn_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_ready,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic [mmrn_pkg::TARGET_BITS-1:0] o_mapped_value,
    input logic                             o_degenerate,
    input logic                             o_saturated
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_mapped_value)
            && $stable(o_degenerate) && $stable(o_saturated))
        else $error("result changed while stalled");

    // A degenerate result is never also clipped
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_degenerate && o_saturated))
        else $error("degenerate and saturated both set");

    // Clipped results sit on a 32-bit rail
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |->
            (o_mapped_value == mmrn_pkg::RESULT_MAX
             || o_mapped_value == mmrn_pkg::RESULT_MIN))
        else $error("saturated result off the rails");

    // Reset empties the pipeline and opens the input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("not empty after reset");

endmodule

bind min_max_range_normalizer mmrn_checker u_mmrn_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_mapped_value (o_mapped_value),
    .o_degenerate   (o_degenerate),
    .o_saturated    (o_saturated)
);

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the min/max range normalizer
// Drives scan and map requests under several target ranges and flow-control
// patterns; each map result, predicted or hand-written, is compared per field.
// ----------------------------------------------------------------------------
module tb;

    localparam int SETTLE_CYCLES   = 48;    // a bit over the map latency
    localparam int ITEMS_PER_PHASE = 155;
    localparam int NUM_PHASES      = 6;

    // Request modes and register indexes used by the directed table
    localparam mmrn_pkg::t_mode MODE_SCAN = mmrn_pkg::MODE_SCAN;
    localparam mmrn_pkg::t_mode MODE_MAP  = mmrn_pkg::MODE_MAP;
    localparam logic [mmrn_pkg::CFG_INDEX_BITS-1:0] CFG_TARGET_LOW  = mmrn_pkg::CFG_TARGET_LOW;
    localparam logic [mmrn_pkg::CFG_INDEX_BITS-1:0] CFG_TARGET_HIGH = mmrn_pkg::CFG_TARGET_HIGH;

    // Register indexes the block must ignore
    localparam logic [mmrn_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [mmrn_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_3 = 2'd3;

    // Empty range: min at the top, max at the bottom
    localparam logic signed [31:0] EMPTY_MIN  = 32'sh7fff_ffff;
    localparam logic signed [31:0] EMPTY_MAX  = 32'sh8000_0000;
    localparam logic [127:0]       QUOT_LIMIT = 128'd1 << 40;

    typedef enum logic { ROW_REQ, ROW_CFG } t_row_kind;

    // One directed step: a request (optionally with a hand-written result)
    // or a register write
    typedef struct packed {
        t_row_kind                           kind;
        mmrn_pkg::t_mode                     mode;
        logic                                first;
        logic [mmrn_pkg::CFG_INDEX_BITS-1:0] index;
        logic [31:0]                         value;
        logic                                typed;
        logic [31:0]                         want_value;
        logic                                want_degen;
        logic                                want_sat;
    } t_step_row;

    localparam int NUM_ROWS = 32;
    localparam t_step_row DIRECTED [NUM_ROWS] = '{
        // empty range right after reset
        '{ROW_REQ, MODE_MAP,  0, CFG_TARGET_LOW,  32'h0000_0000, 1, 32'h0000_0000, 1, 0},
        '{ROW_CFG, MODE_SCAN, 0, CFG_SPARE_2,     32'h1234_5678, 0, 32'h0000_0000, 0, 0},
        '{ROW_CFG, MODE_SCAN, 0, CFG_SPARE_3,     32'hffff_ffff, 0, 32'h0000_0000, 0, 0},
        // first flag on a map request does nothing
        '{ROW_REQ, MODE_MAP,  1, CFG_TARGET_LOW,  32'h7fff_ffff, 1, 32'h0000_0000, 1, 0},
        // zero-width range
        '{ROW_REQ, MODE_SCAN, 1, CFG_TARGET_LOW,  32'h0000_0000, 0, 32'h0000_0000, 0, 0},
        '{ROW_REQ, MODE_MAP,  0, CFG_TARGET_LOW,  32'h0000_0000, 1, 32'h0000_0000, 1, 0},
        // range [0, 1.0] onto default target [0, 1.0]
        '{ROW_REQ, MODE_SCAN, 0, CFG_TARGET_LOW,  32'h0001_0000, 0, 32'h0000_0000, 0, 0},
        '{ROW_REQ, MODE_MAP,  0, CFG_TARGET_LOW,  32'h0000_0000, 1, 32'h0000_0000, 0, 0},
        '{ROW_REQ, MODE_MAP,  0, CFG_TARGET_LOW,  32'h0001_0000, 1, 32'h0001_0000, 0, 0},
        '{ROW_REQ, MODE_MAP,  0, CFG_TARGET_LOW,  32'hffff_0000, 0, 32'h0000_0000, 0, 0},
        '{ROW_REQ, MODE_MAP,  1, CFG_TARGET_LOW,  32'h0001_0000, 1, 32'h0001_0000, 0, 0},
        // restart where one sample sets both min and max, then a new min
        '{ROW_REQ, MODE_SCAN, 1, CFG_TARGET_LOW,  32'h0000_0064, 0, 32'h0000_0000, 0, 0},
        '{ROW_REQ, MODE_SCAN, 0, CFG_TARGET_LOW,  32'h0000_0032, 0, 32'h0000_0000, 0, 0},
        '{ROW_REQ, MODE_MAP,  0, CFG_TARGET_LOW,  32'h0000_0064, 1, 32'h0001_0000, 0, 0},
        // full-scale range and target
        '{ROW_CFG, MODE_SCAN, 0, CFG_TARGET_LOW,  32'h8000_0000, 0, 32'h0000_0000, 0, 0},
        '{ROW_CFG, MODE_SCAN, 0, CFG_TARGET_HIGH, 32'h7fff_ffff, 0, 32'h0000_0000, 0, 0},
        '{ROW_REQ, MODE_SCAN, 1, CFG_TARGET_LOW,  32'h8000_0000, 0, 32'h0000_0000, 0, 0},
        '{ROW_REQ, MODE_SCAN, 0, CFG_TARGET_LOW,  32'h7fff_ffff, 0, 32'h0000_0000, 0, 0},
        '{ROW_REQ, MODE_MAP,  0, CFG_TARGET_LOW,  32'h8000_0000, 1, 32'h8000_0000, 0, 0},
        '{ROW_REQ, MODE_MAP,  0, CFG_TARGET_LOW,  32'h7fff_ffff, 1, 32'h7fff_ffff, 0, 0},
        '{ROW_REQ, MODE_MAP,  0, CFG_TARGET_LOW,  32'h0000_0000, 0, 32'h0000_0000, 0, 0},
        // one-LSB range: samples far outside clip both ways
        '{ROW_REQ, MODE_SCAN, 1, CFG_TARGET_LOW,  32'h0000_0000, 0, 32'h0000_0000, 0, 0},
        '{ROW_REQ, MODE_SCAN, 0, CFG_TARGET_LOW,  32'h0000_0001, 0, 32'h0000_0000, 0, 0},
        '{ROW_REQ, MODE_MAP,  0, CFG_TARGET_LOW,  32'h7fff_ffff, 1, 32'h7fff_ffff, 0, 1},
        '{ROW_REQ, MODE_MAP,  0, CFG_TARGET_LOW,  32'h8000_0000, 1, 32'h8000_0000, 0, 1},
        // inverted target
        '{ROW_CFG, MODE_SCAN, 0, CFG_TARGET_LOW,  32'h7fff_ffff, 0, 32'h0000_0000, 0, 0},
        '{ROW_CFG, MODE_SCAN, 0, CFG_TARGET_HIGH, 32'h8000_0000, 0, 32'h0000_0000, 0, 0},
        '{ROW_REQ, MODE_MAP,  0, CFG_TARGET_LOW,  32'h0000_0000, 1, 32'h7fff_ffff, 0, 0},
        '{ROW_REQ, MODE_MAP,  0, CFG_TARGET_LOW,  32'h0000_0001, 1, 32'h8000_0000, 0, 0},
        '{ROW_REQ, MODE_MAP,  0, CFG_TARGET_LOW,  32'h0000_0002, 0, 32'h0000_0000, 0, 0},
        // restart with a single sample
        '{ROW_REQ, MODE_SCAN, 1, CFG_TARGET_LOW,  32'h0000_0005, 0, 32'h0000_0000, 0, 0},
        '{ROW_REQ, MODE_MAP,  0, CFG_TARGET_LOW,  32'h0000_0005, 1, 32'h7fff_ffff, 1, 0}
    };

    // DUT ports
    logic                                i_clk           = 1'b0;
    logic                                i_rst_n         = 1'b0;
    logic                                i_valid         = 1'b0;
    logic                                o_ready;
    logic                                i_mode          = 1'b0;
    logic                                i_first_of_scan = 1'b0;
    logic [31:0]                         i_sample_value  = '0;
    logic                                o_valid;
    logic                                i_ready         = 1'b0;
    logic [mmrn_pkg::TARGET_BITS-1:0]    o_mapped_value;
    logic                                o_degenerate;
    logic                                o_saturated;
    logic                                i_cfg_we        = 1'b0;
    logic [mmrn_pkg::CFG_INDEX_BITS-1:0] i_cfg_index     = '0;
    logic [mmrn_pkg::TARGET_BITS-1:0]    i_cfg_data      = '0;

    // Predictor state
    logic signed [31:0] span_min  = EMPTY_MIN;
    logic signed [31:0] span_max  = EMPTY_MAX;
    logic signed [31:0] tgt_low   = mmrn_pkg::TARGET_LOW_RST;
    logic signed [31:0] tgt_high  = mmrn_pkg::TARGET_HIGH_RST;
    mmrn_pkg::t_result  pending_maps [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int n_scans = 0, n_maps = 0, n_checked = 0, n_degen = 0, n_sat = 0;
    int n_cfg   = 0, n_fail = 0;

    min_max_range_normalizer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_first_of_scan(i_first_of_scan),
        .i_sample_value (i_sample_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_mapped_value (o_mapped_value),
        .o_degenerate   (o_degenerate),
        .o_saturated    (o_saturated),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Scan requests move the range; map requests queue the rescaled result
    function automatic void predict_request(mmrn_pkg::t_mode mode, logic first,
                                            logic [31:0] value);
        logic signed [31:0] v;
        longint             dv, dt, dr, dv_mag, dt_mag, q, sum;
        logic [127:0]       prod, quot;
        logic               neg;
        mmrn_pkg::t_result  r;
        v = value;
        if (mode == MODE_SCAN) begin
            n_scans++;
            if (first) begin
                span_min = EMPTY_MIN;
                span_max = EMPTY_MAX;
            end
            // independent compares: one sample may set both ends
            if (v < span_min) span_min = v;
            if (v > span_max) span_max = v;
            return;
        end
        n_maps++;
        r.mapped_value = tgt_low;
        r.degenerate   = 1'b1;
        r.saturated    = 1'b0;
        if (span_max > span_min) begin
            r.degenerate = 1'b0;
            dv     = longint'(v) - longint'(span_min);
            dt     = longint'(tgt_high) - longint'(tgt_low);
            dr     = longint'(span_max) - longint'(span_min);
            neg    = (dv < 0) != (dt < 0);
            dv_mag = (dv < 0) ? -dv : dv;
            dt_mag = (dt < 0) ? -dt : dt;
            prod   = 128'(dv_mag) * 128'(dt_mag);
            quot   = prod / 128'(dr);
            if (quot > QUOT_LIMIT) begin
                r.mapped_value = neg ? mmrn_pkg::RESULT_MIN : mmrn_pkg::RESULT_MAX;
                r.saturated    = 1'b1;
            end else begin
                q   = longint'(quot[63:0]);
                sum = longint'(tgt_low) + (neg ? -q : q);
                if (sum > longint'(mmrn_pkg::RESULT_MAX)) begin
                    sum         = longint'(mmrn_pkg::RESULT_MAX);
                    r.saturated = 1'b1;
                end else if (sum < longint'(mmrn_pkg::RESULT_MIN)) begin
                    sum         = longint'(mmrn_pkg::RESULT_MIN);
                    r.saturated = 1'b1;
                end
                r.mapped_value = sum[31:0];
            end
        end
        pending_maps.push_back(r);
    endfunction

    // Present one request, with random idle cycles first; valid stays high
    task automatic push_req(mmrn_pkg::t_mode mode, logic first, logic [31:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_mode          <= mode;
        i_first_of_scan <= first;
        i_sample_value  <= value;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Stop sending until every result is back and the back end has settled
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_maps.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [mmrn_pkg::CFG_INDEX_BITS-1:0] index, logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            CFG_TARGET_LOW:  tgt_low  = data;
            CFG_TARGET_HIGH: tgt_high = data;
            default: ;
        endcase
        n_cfg++;
        @(posedge i_clk);
    endtask

    // Result checker and random receiver stalls
    always @(posedge i_clk) begin : result_check
        mmrn_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_maps.size() == 0) begin
                $error("result with nothing expected: mapped_value %h", o_mapped_value);
                n_fail++;
            end else begin
                want = pending_maps.pop_front();
                n_checked++;
                n_degen += o_degenerate;
                n_sat   += o_saturated;
                if (o_mapped_value !== want.mapped_value) begin
                    $error("mapped_value: expected %h, got %h",
                           want.mapped_value, o_mapped_value);
                    n_fail++;
                end
                if (o_degenerate !== want.degenerate) begin
                    $error("degenerate: expected %b, got %b", want.degenerate, o_degenerate);
                    n_fail++;
                end
                if (o_saturated !== want.saturated) begin
                    $error("saturated: expected %b, got %b", want.saturated, o_saturated);
                    n_fail++;
                end
            end
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Stimulus
    initial begin : stimulus
        t_step_row         row;
        mmrn_pkg::t_result typed_want;
        mmrn_pkg::t_mode   md;
        logic              first;
        logic [31:0]       lo, hi, center, spread, value;
        longint            dr;
        int                sent, nscan, nmap, k;
        bit                paused;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (int i = 0; i < NUM_ROWS; i++) begin
            row = DIRECTED[i];
            if (row.kind == ROW_CFG) begin
                drain();
                cfg_write(row.index, row.value);
            end else begin
                push_req(row.mode, row.first, row.value);
                if (row.typed) begin
                    typed_want.mapped_value = row.want_value;
                    typed_want.degenerate   = row.want_degen;
                    typed_want.saturated    = row.want_sat;
                    pending_maps.push_back(typed_want);
                    n_maps++;
                end else begin
                    predict_request(row.mode, row.first, row.value);
                end
            end
        end

        // Random phases, each with its own target range and one of four flow patterns
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            case (p)
                0: begin lo = mmrn_pkg::TARGET_LOW_RST; hi = mmrn_pkg::TARGET_HIGH_RST; end
                1: begin lo = $urandom;                 hi = $urandom;                  end
                2: begin lo = mmrn_pkg::RESULT_MIN;     hi = mmrn_pkg::RESULT_MAX;      end
                3: begin lo = mmrn_pkg::RESULT_MAX;     hi = mmrn_pkg::RESULT_MIN;      end
                4: begin lo = $urandom;                 hi = lo;                        end
                default: begin
                    lo = $urandom_range(32'h0020_0000) - 32'h0010_0000;
                    hi = lo + $urandom_range(32'h0010_0000);
                end
            endcase
            cfg_write(CFG_TARGET_LOW, lo);
            cfg_write(CFG_TARGET_HIGH, hi);

            sent   = 0;
            paused = 0;
            while (sent < ITEMS_PER_PHASE) begin
                // hold off once per phase until the pipeline is empty
                if (!paused && sent >= ITEMS_PER_PHASE / 2) begin
                    drain();
                    paused = 1;
                end
                if ($urandom_range(99) < 80) begin
                    // a scan pass followed by a few map requests
                    nscan  = $urandom_range(1, 8);
                    center = $urandom;
                    spread = 32'hffff_ffff >> $urandom_range(31);
                    for (k = 0; k < nscan; k++) begin
                        value = center + ($urandom & spread);
                        push_req(MODE_SCAN, k == 0, value);
                        predict_request(MODE_SCAN, k == 0, value);
                    end
                    nmap = $urandom_range(1, 6);
                    for (k = 0; k < nmap; k++) begin
                        dr = longint'(span_max) - longint'(span_min);
                        case ($urandom_range(3))
                            0: value = $urandom;
                            1: value = $urandom_range(1) ? span_min : span_max;
                            default:
                                value = (dr > 0) ? 32'(longint'(span_min)
                                        + longint'($urandom) % (dr + 1)) : span_min;
                        endcase
                        push_req(MODE_MAP, $urandom_range(1), value);
                        predict_request(MODE_MAP, 1'b0, value);
                    end
                    sent += nscan + nmap;
                end else begin
                    // noise: any mode, any flag, any sample
                    nscan = $urandom_range(1, 4);
                    for (k = 0; k < nscan; k++) begin
                        md    = mmrn_pkg::t_mode'($urandom_range(1));
                        first = $urandom_range(1);
                        value = $urandom;
                        push_req(md, first, value);
                        predict_request(md, first, value);
                    end
                    sent += nscan;
                end
            end
        end

        drain();
        $display("Sent %0d scan and %0d map requests, %0d register writes, %0d target settings.",
                 n_scans, n_maps, n_cfg, NUM_PHASES + 3);
        $display("Checked %0d results (%0d degenerate, %0d saturated), %0d failures.",
                 n_checked, n_degen, n_sat, n_fail);
        if (n_fail == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(5_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
